FILE: sv/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and constants for the decision tree traversal block: default
// sizes, field widths, item codes and the command word passed front to back.
// ----------------------------------------------------------------------------
package dtt_pkg;

    localparam int DTT_MAX_NODES    = 1024;
    localparam int DTT_MAX_FEATURES = 64;
    localparam int DTT_VALUE_WIDTH  = 64;

    localparam int OP_W     = 2;
    localparam int IDX_W    = 10;
    localparam int FEAT_W   = 6;
    localparam int DATA_W   = 64;

    localparam int CMD_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_NODE     = 2'd0,
        OP_FVAL     = 2'd1,
        OP_FKIND    = 2'd2,
        OP_CLASSIFY = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic               addr_ok;
        logic [IDX_W-1:0]   idx;
        logic [IDX_W-1:0]   left;
        logic [IDX_W-1:0]   right;
        logic [FEAT_W-1:0]  sfeat;
        logic [DATA_W-1:0]  value;
        logic               ordered;
    } cmd_t;

endpackage

FILE: sv/dtt_front.sv
// ----------------------------------------------------------------------------
// dtt_front
// Decodes an incoming item into a command word: resolves the code, merges
// the index and value fields and checks the target address against the sizes.
// ----------------------------------------------------------------------------
module dtt_front #(
    parameter int MAX_NODES    = dtt_pkg::DTT_MAX_NODES,
    parameter int MAX_FEATURES = dtt_pkg::DTT_MAX_FEATURES
) (
    input  logic [dtt_pkg::OP_W-1:0]    opcode,
    input  logic [dtt_pkg::IDX_W-1:0]   node_index,
    input  logic [dtt_pkg::IDX_W-1:0]   left_child,
    input  logic [dtt_pkg::IDX_W-1:0]   right_child,
    input  logic [dtt_pkg::FEAT_W-1:0]  split_feature,
    input  logic signed [dtt_pkg::DATA_W-1:0] node_value,
    input  logic [dtt_pkg::FEAT_W-1:0]  feature_index,
    input  logic signed [dtt_pkg::DATA_W-1:0] feature_value,
    input  logic                        feature_is_ordered,
    output dtt_pkg::cmd_t               cmd
);
    import dtt_pkg::*;

    op_t  op;
    logic node_ok;
    logic feat_ok;

    always_comb
    begin
        op      = op_t'(opcode);
        node_ok = 32'(node_index) < 32'(MAX_NODES);
        feat_ok = 32'(feature_index) < 32'(MAX_FEATURES);

        cmd.op      = op;
        cmd.left    = left_child;
        cmd.right   = right_child;
        cmd.sfeat   = split_feature;
        cmd.ordered = feature_is_ordered;
        case (op)
            OP_NODE:
            begin
                cmd.addr_ok = node_ok;
                cmd.idx     = node_index;
                cmd.value   = node_value;
            end
            OP_FVAL:
            begin
                cmd.addr_ok = feat_ok;
                cmd.idx     = IDX_W'(feature_index);
                cmd.value   = feature_value;
            end
            OP_FKIND:
            begin
                cmd.addr_ok = feat_ok;
                cmd.idx     = IDX_W'(feature_index);
                cmd.value   = node_value;
            end
            default:
            begin
                cmd.addr_ok = 1'b1;
                cmd.idx     = node_index;
                cmd.value   = node_value;
            end
        endcase
    end

endmodule

FILE: sv/dtt_cmd_fifo.sv
// ----------------------------------------------------------------------------
// dtt_cmd_fifo
// Short command queue between the decoder and the tree walker.
// ----------------------------------------------------------------------------
module dtt_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  dtt_pkg::cmd_t   wr_cmd,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output dtt_pkg::cmd_t   rd_cmd
);
    import dtt_pkg::*;

    localparam int AW    = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             mem [CMD_DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = count_reg == CNT_W'(CMD_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == CMD_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == CMD_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

FILE: sv/dtt_back.sv
// ----------------------------------------------------------------------------
// dtt_back
// Tree and sample stores with the walker. Executes write items as they are
// popped and walks a classify item node by node: node fetch, feature fetch,
// decide. Sweeps the node store and kind flags clear after reset.
// ----------------------------------------------------------------------------
module dtt_back #(
    parameter int MAX_NODES    = dtt_pkg::DTT_MAX_NODES,
    parameter int MAX_FEATURES = dtt_pkg::DTT_MAX_FEATURES,
    parameter int VALUE_WIDTH  = dtt_pkg::DTT_VALUE_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  dtt_pkg::cmd_t               cmd,
    output logic                        cmd_pop,
    output logic                        clearing,
    output logic                        res_valid,
    input  logic                        res_pop,
    output logic [dtt_pkg::IDX_W-1:0]   leaf_index,
    output logic signed [dtt_pkg::DATA_W-1:0] leaf_value,
    output logic                        walk_error
);
    import dtt_pkg::*;

    localparam int VW      = VALUE_WIDTH;
    localparam int FRAC    = VW / 2;
    localparam int INT_B   = VW - FRAC;
    localparam int POS_W   = $clog2(INT_B);
    localparam int NODE_AW = $clog2(MAX_NODES);
    localparam int FEAT_AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CLR_N   = (MAX_NODES > MAX_FEATURES) ? MAX_NODES : MAX_FEATURES;
    localparam int CLR_W   = $clog2(CLR_N + 1);
    localparam int HOP_W   = $clog2(MAX_NODES + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FETCH  = 4'b0010,
        S_TEST   = 4'b0100,
        S_DECIDE = 4'b1000
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0]  left;
        logic [IDX_W-1:0]  right;
        logic [FEAT_W-1:0] sfeat;
        logic [VW-1:0]     thr;
    } node_t;

    node_t          node_mem [MAX_NODES];
    logic [VW-1:0]  fval_mem [MAX_FEATURES];
    logic           kind_mem [MAX_FEATURES];

    state_t             state_reg;
    state_t             state_next;
    logic               clear_reg;
    logic               clear_next;
    logic [CLR_W-1:0]   clr_cnt_reg;
    logic [CLR_W-1:0]   clr_cnt_next;
    logic [IDX_W-1:0]   node_reg;
    logic [IDX_W-1:0]   node_next;
    logic [HOP_W-1:0]   hops_reg;
    logic [HOP_W-1:0]   hops_next;
    logic               res_valid_reg;
    logic               res_valid_next;
    logic [IDX_W-1:0]   res_node_reg;
    logic [VW-1:0]      res_value_reg;
    logic               res_err_reg;
    logic               feat_ok_reg;
    node_t              nd_reg;
    logic [VW-1:0]      fv_reg;
    logic               kind_reg;

    logic               node_we;
    logic [NODE_AW-1:0] node_wa;
    node_t              node_wd;
    logic               kind_we;
    logic [FEAT_AW-1:0] kind_wa;
    logic               kind_wd;
    logic               fval_we;
    logic               fin;
    logic [VW-1:0]      fin_value;
    logic               fin_err;
    logic               node_oor;
    logic               is_leaf;
    logic               hop_limit;
    logic [VW-1:0]      val;
    logic               ord;
    logic [INT_B-1:0]   fl;
    logic [INT_B-1:0]   thr_int;
    logic [POS_W-1:0]   pos;
    logic               cat_right;
    logic               go_left;

    assign clearing   = clear_reg;
    assign res_valid  = res_valid_reg;
    assign leaf_index = res_node_reg;
    assign leaf_value = DATA_W'($signed(res_value_reg));
    assign walk_error = res_err_reg;

    assign cmd_pop = !clear_reg && state_reg == S_IDLE && cmd_valid
                     && (cmd.op != OP_CLASSIFY || !res_valid_reg);

    always_comb
    begin
        node_we = 1'b0;
        node_wa = NODE_AW'(cmd.idx);
        node_wd = '{left: cmd.left, right: cmd.right, sfeat: cmd.sfeat,
                    thr: cmd.value[VW-1:0]};
        kind_we = 1'b0;
        kind_wa = FEAT_AW'(cmd.idx);
        kind_wd = cmd.ordered;
        fval_we = 1'b0;
        if (clear_reg)
        begin
            node_we = 32'(clr_cnt_reg) < MAX_NODES;
            node_wa = NODE_AW'(clr_cnt_reg);
            node_wd = '0;
            kind_we = 32'(clr_cnt_reg) < MAX_FEATURES;
            kind_wa = FEAT_AW'(clr_cnt_reg);
            kind_wd = 1'b0;
        end
        else if (cmd_pop && cmd.addr_ok)
        begin
            case (cmd.op)
                OP_NODE:  node_we = 1'b1;
                OP_FVAL:  fval_we = 1'b1;
                OP_FKIND: kind_we = 1'b1;
                default:  node_we = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        val       = feat_ok_reg ? fv_reg : '0;
        ord       = feat_ok_reg && kind_reg;
        fl        = val[VW-1:FRAC];
        thr_int   = nd_reg.thr[VW-1:FRAC];
        pos       = POS_W'(fl - 1'b1);
        cat_right = !fl[INT_B-1] && fl != '0 && fl <= INT_B'(INT_B) && thr_int[pos];
        go_left   = ord ? ($signed(val) <= $signed(nd_reg.thr)) : !cat_right;
        node_oor  = 32'(node_reg) >= 32'(MAX_NODES);
        is_leaf   = nd_reg.left == '0 && nd_reg.right == '0;
        hop_limit = hops_reg >= HOP_W'(MAX_NODES);
    end

    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        hops_next      = hops_reg;
        clear_next     = clear_reg;
        clr_cnt_next   = clr_cnt_reg;
        res_valid_next = res_valid_reg && !res_pop;
        fin            = 1'b0;
        fin_value      = '0;
        fin_err        = 1'b0;

        if (clear_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (32'(clr_cnt_reg) == CLR_N - 1)
            begin
                clear_next = 1'b0;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop && cmd.op == OP_CLASSIFY)
                begin
                    node_next  = '0;
                    hops_next  = '0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (node_oor)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (is_leaf)
                begin
                    fin        = 1'b1;
                    fin_value  = nd_reg.thr;
                    state_next = S_IDLE;
                end
                else if (hop_limit)
                begin
                    fin        = 1'b1;
                    fin_err    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                node_next  = go_left ? nd_reg.left : nd_reg.right;
                hops_next  = hops_reg + 1'b1;
                state_next = S_FETCH;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clear_reg     <= 1'b1;
            clr_cnt_reg   <= '0;
            node_reg      <= '0;
            hops_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_reg     <= clear_next;
            clr_cnt_reg   <= clr_cnt_next;
            node_reg      <= node_next;
            hops_reg      <= hops_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            res_node_reg  <= node_reg;
            res_value_reg <= fin_value;
            res_err_reg   <= fin_err;
        end
        if (state_reg == S_TEST)
        begin
            feat_ok_reg <= 32'(nd_reg.sfeat) < 32'(MAX_FEATURES);
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_wa] <= node_wd;
        end
        if (state_reg == S_FETCH)
        begin
            nd_reg <= node_mem[NODE_AW'(node_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fval_we)
        begin
            fval_mem[FEAT_AW'(cmd.idx)] <= cmd.value[VW-1:0];
        end
        if (state_reg == S_TEST)
        begin
            fv_reg <= fval_mem[FEAT_AW'(nd_reg.sfeat)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (kind_we)
        begin
            kind_mem[kind_wa] <= kind_wd;
        end
        if (state_reg == S_TEST)
        begin
            kind_reg <= kind_mem[FEAT_AW'(nd_reg.sfeat)];
        end
    end

endmodule

FILE: sv/decision_tree_traversal.sv
// ----------------------------------------------------------------------------
// decision_tree_traversal
// Decision tree inference: loads a node store, feature kinds and one sample,
// then walks the tree from the root for each classify word.
//
//   channel   handshake         payload
//   input     push / full       opcode, node/child/feature indices, values
//   result    empty / pop       leaf_index, leaf_value, walk_error
//
// Write words are executed as they leave the queue; a classify word walks the
// tree node by node through the node fetch, feature fetch and decide steps.
// After reset the node store and kind flags are swept clear, one entry a
// cycle up to max(MAX_NODES, MAX_FEATURES) entries, with full held high.
// A two-word queue lets input words arrive while the walker is busy or a
// result waits; a classify word waits until the previous result is taken.
// ----------------------------------------------------------------------------
module decision_tree_traversal #(
    parameter int MAX_NODES    = dtt_pkg::DTT_MAX_NODES,
    parameter int MAX_FEATURES = dtt_pkg::DTT_MAX_FEATURES,
    parameter int VALUE_WIDTH  = dtt_pkg::DTT_VALUE_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [dtt_pkg::OP_W-1:0]    opcode,
    input  logic [dtt_pkg::IDX_W-1:0]   node_index,
    input  logic [dtt_pkg::IDX_W-1:0]   left_child,
    input  logic [dtt_pkg::IDX_W-1:0]   right_child,
    input  logic [dtt_pkg::FEAT_W-1:0]  split_feature,
    input  logic signed [dtt_pkg::DATA_W-1:0] node_value,
    input  logic [dtt_pkg::FEAT_W-1:0]  feature_index,
    input  logic signed [dtt_pkg::DATA_W-1:0] feature_value,
    input  logic                        feature_is_ordered,
    output logic                        empty,
    input  logic                        pop,
    output logic [dtt_pkg::IDX_W-1:0]   leaf_index,
    output logic signed [dtt_pkg::DATA_W-1:0] leaf_value,
    output logic                        walk_error
);
    import dtt_pkg::*;

    cmd_t in_cmd;
    cmd_t q_cmd;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic clearing;
    logic res_valid;

    assign full  = q_full || clearing;
    assign empty = !res_valid;

    dtt_front #(
        .MAX_NODES    (MAX_NODES),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_front (
        .opcode             (opcode),
        .node_index         (node_index),
        .left_child         (left_child),
        .right_child        (right_child),
        .split_feature      (split_feature),
        .node_value         (node_value),
        .feature_index      (feature_index),
        .feature_value      (feature_value),
        .feature_is_ordered (feature_is_ordered),
        .cmd                (in_cmd)
    );

    dtt_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push && !full),
        .wr_cmd   (in_cmd),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd)
    );

    dtt_back #(
        .MAX_NODES    (MAX_NODES),
        .MAX_FEATURES (MAX_FEATURES),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_valid),
        .cmd        (q_cmd),
        .cmd_pop    (q_pop),
        .clearing   (clearing),
        .res_valid  (res_valid),
        .res_pop    (pop && res_valid),
        .leaf_index (leaf_index),
        .leaf_value (leaf_value),
        .walk_error (walk_error)
    );

endmodule

FILE: test/tb_decision_tree_traversal.sv
// ----------------------------------------------------------------------------
// tb_decision_tree_traversal
// Self-checking bench for the decision tree traversal block. The bench loads
// random trees, sample values and feature kinds through the input queue and
// predicts every classify walk in a scoreboard that keeps its own node store.
// Results are checked in order against the predicted leaf. Both sides idle at
// random, and the run includes a long result back-pressure stretch and
// cycle-guard walks.
// ----------------------------------------------------------------------------
module tb_decision_tree_traversal;

    timeunit 1ns;
    timeprecision 1ps;

    import dtt_pkg::*;

    localparam int NODES       = DTT_MAX_NODES;
    localparam int FEATURES    = DTT_MAX_FEATURES;
    localparam int HALF        = DATA_W / 2;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_WORDS = 500;

    localparam logic signed [DATA_W-1:0] Q_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] Q_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_THREE = 64'sh3_0000_0000;

    typedef struct {
        op_t                       op;
        logic [IDX_W-1:0]          node_index;
        logic [IDX_W-1:0]          left_child;
        logic [IDX_W-1:0]          right_child;
        logic [FEAT_W-1:0]         split_feature;
        logic signed [DATA_W-1:0]  node_value;
        logic [FEAT_W-1:0]         feature_index;
        logic signed [DATA_W-1:0]  feature_value;
        logic                      feature_is_ordered;
    } tree_word_t;

    typedef struct {
        logic [IDX_W-1:0]          leaf_index;
        logic signed [DATA_W-1:0]  leaf_value;
        logic                      walk_error;
    } leaf_t;

    class leaf_scoreboard;
        logic [IDX_W-1:0]          left_of [NODES];
        logic [IDX_W-1:0]          right_of [NODES];
        logic [FEAT_W-1:0]         feat_of [NODES];
        logic signed [DATA_W-1:0]  split_of [NODES];
        bit                        ordered_of [FEATURES];
        logic signed [DATA_W-1:0]  sample [FEATURES];
        leaf_t                     expected_leaves [$];
        int                        words;
        int                        walks;
        int                        guard_stops;
        int                        checked;
        int                        failures;

        function new();
            foreach (left_of[i])
            begin
                left_of[i]  = '0;
                right_of[i] = '0;
                feat_of[i]  = '0;
                split_of[i] = '0;
            end
            foreach (sample[i])
            begin
                sample[i]     = '0;
                ordered_of[i] = 1'b0;
            end
        endfunction

        function bit goes_left(int unsigned n);
            logic [FEAT_W-1:0]         f;
            logic signed [DATA_W-1:0]  v;
            logic signed [DATA_W-1:0]  whole;
            logic signed [DATA_W-1:0]  cats;
            f = feat_of[n];
            v = sample[f];
            if (ordered_of[f])
                return v <= split_of[n];
            whole = v >>> HALF;
            if (whole < 1 || whole > HALF)
                return 1'b1;
            cats = split_of[n] >>> HALF;
            return cats[int'(whole) - 1] == 1'b0;
        endfunction

        function leaf_t walk_tree();
            leaf_t       r;
            int unsigned n;
            int unsigned hops;
            n = 0;
            hops = 0;
            r.walk_error = 1'b0;
            while (1)
            begin
                if (left_of[n] == '0 && right_of[n] == '0)
                begin
                    r.leaf_value = split_of[n];
                    break;
                end
                if (hops >= NODES)
                begin
                    r.walk_error = 1'b1;
                    r.leaf_value = '0;
                    break;
                end
                n = goes_left(n) ? 32'(left_of[n]) : 32'(right_of[n]);
                hops++;
            end
            r.leaf_index = IDX_W'(n);
            return r;
        endfunction

        function void note_word(tree_word_t w);
            leaf_t lf;
            words++;
            case (w.op)
                OP_NODE:
                begin
                    left_of[w.node_index]  = w.left_child;
                    right_of[w.node_index] = w.right_child;
                    feat_of[w.node_index]  = w.split_feature;
                    split_of[w.node_index] = w.node_value;
                end
                OP_FVAL:  sample[w.feature_index] = w.feature_value;
                OP_FKIND: ordered_of[w.feature_index] = w.feature_is_ordered;
                default:
                begin
                    lf = walk_tree();
                    expected_leaves = {expected_leaves, lf};
                    walks++;
                    if (lf.walk_error)
                        guard_stops++;
                end
            endcase
        endfunction

        function void check_leaf(leaf_t got);
            leaf_t want;
            checked++;
            if (expected_leaves.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: node %0d value %h error %b",
                             got.leaf_index, got.leaf_value, got.walk_error);
                return;
            end
            want = expected_leaves.pop_front();
            if (got.leaf_index !== want.leaf_index || got.leaf_value !== want.leaf_value ||
                got.walk_error !== want.walk_error)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $write("result %0d: expected node %0d value %h error %b, ",
                           checked, want.leaf_index, want.leaf_value, want.walk_error);
                    $display("got node %0d value %h error %b",
                             got.leaf_index, got.leaf_value, got.walk_error);
                end
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      push = 1'b0;
    logic                      full;
    logic [OP_W-1:0]           opcode = '0;
    logic [IDX_W-1:0]          node_index = '0;
    logic [IDX_W-1:0]          left_child = '0;
    logic [IDX_W-1:0]          right_child = '0;
    logic [FEAT_W-1:0]         split_feature = '0;
    logic signed [DATA_W-1:0]  node_value = '0;
    logic [FEAT_W-1:0]         feature_index = '0;
    logic signed [DATA_W-1:0]  feature_value = '0;
    logic                      feature_is_ordered = 1'b0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic [IDX_W-1:0]          leaf_index;
    logic signed [DATA_W-1:0]  leaf_value;
    logic                      walk_error;

    leaf_scoreboard leaves = new();
    bit             fval_known [FEATURES];
    bit             in_tree [NODES];
    int             sent = 0;
    bit             calm = 1'b0;
    int             hold_len = 0;

    decision_tree_traversal DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .opcode             (opcode),
        .node_index         (node_index),
        .left_child         (left_child),
        .right_child        (right_child),
        .split_feature      (split_feature),
        .node_value         (node_value),
        .feature_index      (feature_index),
        .feature_value      (feature_value),
        .feature_is_ordered (feature_is_ordered),
        .empty              (empty),
        .pop                (pop),
        .leaf_index         (leaf_index),
        .leaf_value         (leaf_value),
        .walk_error         (walk_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic signed [DATA_W-1:0] near_value();
        int ip;
        case ($urandom_range(0, 9))
            0: return rand64();
            1: return Q_MIN;
            2: return Q_MAX;
            default: ip = int'($urandom_range(0, 16)) - 8;
        endcase
        return {ip, $urandom};
    endfunction

    function automatic logic signed [DATA_W-1:0] category_value();
        int ip;
        case ($urandom_range(0, 9))
            0: ip = 0;
            1: ip = $urandom_range(HALF + 1, 2 * HALF);
            2: ip = -int'($urandom_range(1, 5));
            3: return rand64();
            default: ip = $urandom_range(1, HALF);
        endcase
        return {ip, $urandom};
    endfunction

    function automatic logic signed [DATA_W-1:0] feature_sample();
        return $urandom_range(0, 1) ? near_value() : category_value();
    endfunction

    function automatic logic signed [DATA_W-1:0] split_sample();
        return ($urandom_range(0, 2) == 0) ? rand64() : near_value();
    endfunction

    function automatic int known_feature();
        int f;
        f = $urandom_range(0, FEATURES - 1);
        while (!fval_known[f])
            f = $urandom_range(0, FEATURES - 1);
        return f;
    endfunction

    function automatic int fresh_node();
        int a;
        a = $urandom_range(1, NODES - 1);
        while (in_tree[a])
            a = $urandom_range(1, NODES - 1);
        in_tree[a] = 1'b1;
        return a;
    endfunction

    function automatic tree_word_t rand_word(op_t op);
        tree_word_t w;
        w.op                 = op;
        w.node_index         = IDX_W'($urandom);
        w.left_child         = IDX_W'($urandom);
        w.right_child        = IDX_W'($urandom);
        w.split_feature      = FEAT_W'($urandom);
        w.node_value         = rand64();
        w.feature_index      = FEAT_W'($urandom);
        w.feature_value      = rand64();
        w.feature_is_ordered = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic push_word(tree_word_t w);
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        push               <= 1'b1;
        opcode             <= w.op;
        node_index         <= w.node_index;
        left_child         <= w.left_child;
        right_child        <= w.right_child;
        split_feature      <= w.split_feature;
        node_value         <= w.node_value;
        feature_index      <= w.feature_index;
        feature_value      <= w.feature_value;
        feature_is_ordered <= w.feature_is_ordered;
        @(posedge clk);
        while (full)
            @(posedge clk);
        leaves.note_word(w);
        sent++;
    endtask

    task automatic send_node(int idx, int l, int r, int f, logic signed [DATA_W-1:0] v);
        tree_word_t w;
        w = rand_word(OP_NODE);
        w.node_index    = IDX_W'(idx);
        w.left_child    = IDX_W'(l);
        w.right_child   = IDX_W'(r);
        w.split_feature = FEAT_W'(f);
        w.node_value    = v;
        push_word(w);
    endtask

    task automatic send_fval(int f, logic signed [DATA_W-1:0] v);
        tree_word_t w;
        w = rand_word(OP_FVAL);
        w.feature_index = FEAT_W'(f);
        w.feature_value = v;
        fval_known[f] = 1'b1;
        push_word(w);
    endtask

    task automatic send_kind(int f, bit ordered);
        tree_word_t w;
        w = rand_word(OP_FKIND);
        w.feature_index      = FEAT_W'(f);
        w.feature_is_ordered = ordered;
        push_word(w);
    endtask

    task automatic send_classify();
        push_word(rand_word(OP_CLASSIFY));
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (leaves.expected_leaves.size() != 0)
            @(posedge clk);
    endtask

    task automatic directed_words();
        send_classify();
        send_fval(0, Q_THREE);
        send_fval(FEATURES - 1, Q_MIN);
        send_fval(1, Q_MAX);
        send_kind(0, 1'b1);
        send_kind(FEATURES - 1, 1'b0);
        send_node(NODES - 1, 0, 0, FEATURES - 1, Q_MAX);
        send_node(5, 0, 0, 0, Q_MIN);
        send_node(0, NODES - 1, 5, 0, Q_THREE);
        send_classify();
        send_fval(0, Q_THREE + 1);
        send_classify();
        send_kind(0, 1'b0);
        send_classify();
        send_node(0, NODES - 1, 5, 1, Q_MIN);
        send_classify();
        send_node(0, NODES - 1, 5, 0, Q_MIN);
        send_fval(0, 64'sh20_8000_0000);
        send_classify();
        send_fval(0, 64'shFFFF_FFFF_8000_0000);
        send_classify();
        send_node(0, 0, NODES - 1, FEATURES - 1, '0);
        send_classify();
    endtask

    task automatic tree_episode(bit squeeze);
        int ids [$];
        int lch [$];
        int rch [$];
        int leaf_pos [$];
        int feats [$];
        int k;
        int p;
        int a;
        int b;
        int f;
        foreach (in_tree[i])
            in_tree[i] = 1'b0;
        in_tree[0] = 1'b1;
        repeat ($urandom_range(1, 4))
        begin
            f = $urandom_range(0, FEATURES - 1);
            feats = {feats, f};
            send_fval(f, feature_sample());
            send_kind(f, 1'($urandom_range(0, 1)));
        end
        ids = {ids, 0};
        lch = {lch, 0};
        rch = {rch, 0};
        leaf_pos = {leaf_pos, 0};
        repeat ($urandom_range(1, 7))
        begin
            k = $urandom_range(0, leaf_pos.size() - 1);
            p = leaf_pos[k];
            leaf_pos.delete(k);
            a = fresh_node();
            b = fresh_node();
            lch[p] = a;
            rch[p] = b;
            leaf_pos = {leaf_pos, ids.size()};
            ids = {ids, a};
            lch = {lch, 0};
            rch = {rch, 0};
            leaf_pos = {leaf_pos, ids.size()};
            ids = {ids, b};
            lch = {lch, 0};
            rch = {rch, 0};
        end
        for (int i = ids.size() - 1; i >= 0; i--)
        begin
            if (lch[i] == 0)
                send_node(ids[i], 0, 0, $urandom_range(0, FEATURES - 1), rand64());
            else
                send_node(ids[i], lch[i], rch[i], feats[$urandom_range(0, feats.size() - 1)],
                          split_sample());
        end
        if (squeeze)
        begin
            hold_len = 400;
            repeat (8) send_classify();
        end
        else
        begin
            repeat ($urandom_range(2, 5))
            begin
                if ($urandom_range(0, 1))
                    send_fval(feats[$urandom_range(0, feats.size() - 1)], feature_sample());
                if ($urandom_range(0, 3) == 0)
                    send_kind(feats[$urandom_range(0, feats.size() - 1)],
                              1'($urandom_range(0, 1)));
                send_classify();
            end
        end
    endtask

    task automatic noise_episode();
        int a;
        int l;
        int r;
        int f;
        repeat ($urandom_range(1, 4))
        begin
            a = $urandom_range(0, NODES - 1);
            case ($urandom_range(0, 5))
                0: send_fval($urandom_range(0, FEATURES - 1), feature_sample());
                1: send_kind($urandom_range(0, FEATURES - 1), 1'($urandom_range(0, 1)));
                2, 3:
                begin
                    l = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, NODES - 1);
                    r = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, NODES - 1);
                    if (l != 0 || r != 0)
                        f = known_feature();
                    else
                        f = $urandom_range(0, FEATURES - 1);
                    send_node(a, l, r, f, split_sample());
                end
                4:
                begin
                    a = $urandom_range(1, NODES - 1);
                    send_node(0, a, a, known_feature(), split_sample());
                    send_node(a, a, a, known_feature(), split_sample());
                end
                default: send_classify();
            endcase
        end
        send_classify();
    endtask

    initial
    begin : stimulus
        int episode;
        int first_random;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        directed_words();
        drain();
        first_random = sent;
        episode = 0;
        while (sent < first_random + RANDOM_WORDS)
        begin
            calm = (episode >= 6 && episode < 10);
            if (episode == 3 || $urandom_range(0, 9) < 7)
                tree_episode(episode == 3);
            else
                noise_episode();
            if (episode % 8 == 7)
                drain();
            episode++;
        end
        calm = 1'b0;
        drain();
        repeat (64) @(posedge clk);
        $display("covered %0d words, %0d classify walks, %0d of them stopped by the hop guard",
                 leaves.words, leaves.walks, leaves.guard_stops);
        $display("checked %0d results, %0d mismatches", leaves.checked, leaves.failures);
        if (leaves.failures == 0 && leaves.expected_leaves.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin : result_side
        leaf_t got;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got.leaf_index = leaf_index;
                got.leaf_value = leaf_value;
                got.walk_error = walk_error;
                leaves.check_leaf(got);
            end
            if (hold_len > 0)
            begin
                pop <= 1'b0;
                hold_len--;
            end
            else
                pop <= calm || $urandom_range(0, 99) >= 25;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("no word moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
sv/dtt_pkg.sv
sv/dtt_front.sv
sv/dtt_cmd_fifo.sv
sv/dtt_back.sv
sv/decision_tree_traversal.sv
test/tb_decision_tree_traversal.sv
